// ===== rtl/locgb_pkg.sv =====
// Shared types and constants of the lidar occupancy grid builder.
package locgb_pkg;

   localparam int GRID_SIDE = 128;
   localparam int COORD_W   = $clog2(GRID_SIDE);
   localparam int ADDR_W    = 2 * COORD_W;
   localparam int SIDE_W    = COORD_W + 1;
   localparam int TALLY_W   = ADDR_W + 1;

   // divider: numerator |2v+c| + 2c - 1 below 2^17, divisor 2c below 2^14
   localparam int NUM_W = 17;
   localparam int DEN_W = 14;
   localparam int CNT_W = $clog2(NUM_W + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   typedef enum logic [CSR_AW-1:0] {
      REG_SPLIT_HEIGHT  = 3'd0,
      REG_OBSTACLE_TOP  = 3'd1,
      REG_GROUND_BOTTOM = 3'd2,
      REG_BOX_HALF      = 3'd3,
      REG_INTENSITY     = 3'd4,
      REG_CELL_SIZE     = 3'd5,
      REG_CELLS_SIDE    = 3'd6
   } csr_index_type;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_POINT  = 2'd1;
   localparam logic [1:0] CMD_FILTER = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [1:0] CLASS_NONE     = 2'd0;
   localparam logic [1:0] CLASS_OBSTACLE = 2'd1;
   localparam logic [1:0] CLASS_GROUND   = 2'd2;

   localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
   localparam logic [1:0] CELL_FREE     = 2'd1;
   localparam logic [1:0] CELL_BRIGHT   = 2'd2;
   localparam logic [1:0] CELL_OBSTACLE = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic [7:0]         point_intensity;
      logic [6:0]         read_col;
      logic [6:0]         read_row;
   } req_type;

   typedef struct packed {
      logic [1:0]  point_class;
      logic [6:0]  cell_col;
      logic [6:0]  cell_row;
      logic [1:0]  cell_code;
      logic [14:0] cells_changed;
      logic        done_res;
   } rsp_type;

endpackage

// ===== rtl/lidar_occupancy_grid_builder_top.sv =====
// Lidar occupancy grid builder: classification, binning and grid store.
//
// One command is taken at a time and answered by exactly one transfer on the
// rsp channel. After reset the block sweeps every cell of the memory to
// unknown before req_ready first rises; a clear command runs the same sweep.
// A kept point passes the bit-serial divider, which bins x and y in parallel,
// then the bin, issue and use states before rsp_valid rises; a discarded
// point goes straight to the finish state, and a read passes the issue and
// use states. A filter visits every cell of the active n by n region through
// the single memory read port: a border cell is skipped at once; otherwise
// each fetch takes a read and an evaluate state, the center first and then
// the eight neighbors in turn, only while the center is unknown and every
// neighbor so far is free. A finished result waits in an output register,
// so the next command can be taken before the result is drained.
module lidar_occupancy_grid_builder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  locgb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output locgb_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [locgb_pkg::CSR_AW-1:0] csr_addr,
   input  logic [locgb_pkg::CSR_DW-1:0] csr_wdata
);
   import locgb_pkg::*;

   typedef enum logic [9:0] {
      S_INIT   = 10'b00_0000_0001,
      S_IDLE   = 10'b00_0000_0010,
      S_CLEAR  = 10'b00_0000_0100,
      S_DIV    = 10'b00_0000_1000,
      S_BIN    = 10'b00_0001_0000,
      S_ISSUE  = 10'b00_0010_0000,
      S_USE    = 10'b00_0100_0000,
      S_F_RD   = 10'b00_1000_0000,
      S_F_EVAL = 10'b01_0000_0000,
      S_FINISH = 10'b10_0000_0000
   } state_type;

   // configuration
   logic signed [15:0] split_ff, top_ff, bottom_ff;
   logic [14:0]        half_ff;
   logic [7:0]         limit_ff;
   logic [12:0]        csize_ff;
   logic [7:0]         cps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff  <= -16'sd1240;
         top_ff    <= 16'sd0;
         bottom_ff <= -16'sd2000;
         half_ff   <= 15'd5000;
         limit_ff  <= 8'd20;
         csize_ff  <= 13'd100;
         cps_ff    <= 8'd101;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SPLIT_HEIGHT:  split_ff  <= csr_wdata;
            REG_OBSTACLE_TOP:  top_ff    <= csr_wdata;
            REG_GROUND_BOTTOM: bottom_ff <= csr_wdata;
            REG_BOX_HALF:      half_ff   <= csr_wdata[14:0];
            REG_INTENSITY:     limit_ff  <= csr_wdata[7:0];
            REG_CELL_SIZE:     csize_ff  <= csr_wdata[12:0];
            REG_CELLS_SIDE:    cps_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // active side and divisor
   logic [SIDE_W-1:0]  side_n;
   logic [COORD_W-1:0] nm1;
   logic [12:0]        csize_eff;
   logic [DEN_W-1:0]   den;

   always_comb begin
      if (cps_ff == 8'd0) side_n = SIDE_W'(1);
      else if ({1'b0, cps_ff} > 9'(GRID_SIDE)) side_n = SIDE_W'(GRID_SIDE);
      else side_n = SIDE_W'(cps_ff);
      nm1       = COORD_W'(side_n - SIDE_W'(1));
      csize_eff = (csize_ff == 13'd0) ? 13'd1 : csize_ff;
      den       = {csize_eff, 1'b0};
   end

   // cell memory
   logic [1:0]        mem [GRID_SIDE*GRID_SIDE];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [1:0]        mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // point classification on the incoming request
   logic signed [16:0] px, py, pz, lo_box, hi_box;
   logic               in_box;
   logic [1:0]         cls_now;
   logic signed [17:0] ax, ay;
   logic [NUM_W-1:0]   ux, uy;

   always_comb begin
      px     = 17'(req_data.point_x);
      py     = 17'(req_data.point_y);
      pz     = 17'(req_data.point_z);
      hi_box = $signed({2'b00, half_ff});
      lo_box = -hi_box;
      in_box = px >= lo_box && px <= hi_box && py >= lo_box && py <= hi_box;
      if (in_box && pz >= 17'(split_ff) && pz <= 17'(top_ff))
         cls_now = CLASS_OBSTACLE;
      else if (in_box && pz >= 17'(bottom_ff) && pz < 17'(split_ff))
         cls_now = CLASS_GROUND;
      else
         cls_now = CLASS_NONE;
      ax = $signed({req_data.point_x[15], req_data.point_x, 1'b0}) +
           $signed({5'b0, csize_eff});
      ay = $signed({req_data.point_y[15], req_data.point_y, 1'b0}) +
           $signed({5'b0, csize_eff});
      // floor of a negative quotient through the magnitude, rounded up
      ux = ax[17] ? NUM_W'(-ax + $signed({4'b0, den}) - 18'sd1) : NUM_W'(ax);
      uy = ay[17] ? NUM_W'(-ay + $signed({4'b0, den}) - 18'sd1) : NUM_W'(ay);
   end

   // registers
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [NUM_W-1:0]   dq_ff [2];
   logic [NUM_W-1:0]   dq_in [2];
   logic [DEN_W-1:0]   drem_ff [2];
   logic [DEN_W-1:0]   drem_in [2];
   logic [1:0]         neg_ff, neg_in;
   logic [CNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [1:0]         cls_ff, cls_in;
   logic [7:0]         inten_ff, inten_in;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [3:0]         nb_ff, nb_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // divider step and bin result
   logic [DEN_W:0]          rem_t [2];
   logic                    ge [2];
   logic signed [NUM_W+1:0] kq [2];
   logic [COORD_W-1:0]      kbin [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rem_t[i] = {drem_ff[i], dq_ff[i][NUM_W-1]};
         ge[i]    = rem_t[i] >= {1'b0, den};
         kq[i]    = neg_ff[i] ? -$signed({2'b00, dq_ff[i]}) : $signed({2'b00, dq_ff[i]});
         kq[i]    = kq[i] + $signed((NUM_W+2)'(side_n >> 1));
         if (kq[i] < 0) kbin[i] = '0;
         else if (kq[i] > $signed((NUM_W+2)'(nm1))) kbin[i] = nm1;
         else kbin[i] = COORD_W'(kq[i]);
      end
   end

   // neighbor offsets: nb 0 is the center, 1..8 the ring
   logic [COORD_W-1:0] ncol, nrow;
   logic               border, last_col, last_row;

   always_comb begin
      ncol = col_ff;
      nrow = row_ff;
      case (nb_ff)
         4'd1: begin ncol = col_ff - 1'b1; nrow = row_ff - 1'b1; end
         4'd2: begin nrow = row_ff - 1'b1; end
         4'd3: begin ncol = col_ff + 1'b1; nrow = row_ff - 1'b1; end
         4'd4: begin ncol = col_ff - 1'b1; end
         4'd5: begin ncol = col_ff + 1'b1; end
         4'd6: begin ncol = col_ff - 1'b1; nrow = row_ff + 1'b1; end
         4'd7: begin nrow = row_ff + 1'b1; end
         4'd8: begin ncol = col_ff + 1'b1; nrow = row_ff + 1'b1; end
         default: ;
      endcase
      last_col = col_ff == nm1;
      last_row = row_ff == nm1;
      border   = col_ff == '0 || row_ff == '0 || last_col || last_row;
   end

   logic [1:0] new_code;

   always_comb begin
      if (cls_ff == CLASS_OBSTACLE || mem_rdata_ff == CELL_OBSTACLE)
         new_code = CELL_OBSTACLE;
      else
         new_code = (inten_ff < limit_ff) ? CELL_FREE : CELL_BRIGHT;
   end

   always_comb begin
      logic advance;
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      dq_in        = dq_ff;
      drem_in      = drem_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      cls_in       = cls_ff;
      inten_in     = inten_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      nb_in        = nb_ff;
      tally_in     = tally_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = CELL_UNKNOWN;
      mem_raddr    = {row_ff, col_ff};
      advance      = 1'b0;

      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1)
               state_in = (state_ff == S_INIT) ? S_IDLE : S_FINISH;
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in          = '0;
               res_in.done_res = 1'b1;
               case (req_data.command)
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_POINT: begin
                     cls_in   = cls_now;
                     inten_in = req_data.point_intensity;
                     dq_in[0] = ux;
                     dq_in[1] = uy;
                     drem_in[0] = '0;
                     drem_in[1] = '0;
                     neg_in   = {ay[17], ax[17]};
                     dcnt_in  = '0;
                     state_in = (cls_now == CLASS_NONE) ? S_FINISH : S_DIV;
                  end
                  CMD_FILTER: begin
                     col_in   = '0;
                     row_in   = '0;
                     nb_in    = '0;
                     tally_in = '0;
                     state_in = S_F_RD;
                  end
                  CMD_READ: begin
                     cls_in   = CLASS_NONE;
                     col_in   = (req_data.read_col > nm1) ? nm1 : req_data.read_col;
                     row_in   = (req_data.read_row > nm1) ? nm1 : req_data.read_row;
                     state_in = S_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            for (int i = 0; i < 2; i++) begin
               drem_in[i] = ge[i] ? DEN_W'(rem_t[i] - {1'b0, den}) : DEN_W'(rem_t[i]);
               dq_in[i]   = {dq_ff[i][NUM_W-2:0], ge[i]};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == CNT_W'(NUM_W - 1)) state_in = S_BIN;
         end
         S_BIN: begin
            col_in   = kbin[0];
            row_in   = kbin[1];
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            state_in = S_USE;
         end
         S_USE: begin
            res_in.cell_col = col_ff;
            res_in.cell_row = row_ff;
            if (cls_ff == CLASS_NONE) begin
               res_in.cell_code = mem_rdata_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = {row_ff, col_ff};
               mem_wdata = new_code;
               res_in.point_class = cls_ff;
               res_in.cell_code   = new_code;
            end
            state_in = S_FINISH;
         end
         S_F_RD: begin
            mem_raddr = {nrow, ncol};
            if (nb_ff == '0 && border) advance = 1'b1;
            else state_in = S_F_EVAL;
         end
         S_F_EVAL: begin
            if (nb_ff == '0 ? mem_rdata_ff != CELL_UNKNOWN : mem_rdata_ff != CELL_FREE) begin
               advance = 1'b1;
            end else if (nb_ff == 4'd8) begin
               mem_we    = 1'b1;
               mem_waddr = {row_ff, col_ff};
               mem_wdata = CELL_FREE;
               tally_in  = tally_ff + 1'b1;
               advance   = 1'b1;
            end else begin
               nb_in    = nb_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // step the filter to the next cell, row by row
      if (advance) begin
         nb_in = '0;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               res_in.cells_changed = 15'(tally_in);
               state_in = S_FINISH;
            end else begin
               row_in = row_ff + 1'b1;
               state_in = S_F_RD;
            end
         end else begin
            col_in   = col_ff + 1'b1;
            state_in = S_F_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dq_ff       <= dq_in;
      drem_ff     <= drem_in;
      neg_ff      <= neg_in;
      dcnt_ff     <= dcnt_in;
      cls_ff      <= cls_in;
      inten_ff    <= inten_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      nb_ff       <= nb_in;
      tally_ff    <= tally_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/tb_lidar_occupancy_grid_builder_top.sv =====
// Self-checking testbench for the lidar occupancy grid builder top level.
module tb_lidar_occupancy_grid_builder_top;
   import locgb_pkg::*;

   localparam int LIMIT_CYCLES = 4000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   lidar_occupancy_grid_builder_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state: register copies and the cell grid
   logic signed [15:0] split_h, obst_top, ground_bot;
   logic [14:0] box_half;
   logic [7:0]  inten_limit;
   logic [12:0] cell_mm;
   logic [7:0]  side_cfg;
   logic [1:0]  grid [0:GRID_SIDE*GRID_SIDE-1];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int issued = 0, checked = 0, errors = 0, cycles = 0;
   int n_points = 0, n_filters = 0, n_reads = 0, n_clears = 0, n_phases = 0;

   function automatic void queue_req(req_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic int active_side();
      if (side_cfg < 1) return 1;
      if (side_cfg > GRID_SIDE) return GRID_SIDE;
      return int'(side_cfg);
   endfunction

   function automatic int bin_axis(int v, int n);
      int c, num, den, q;
      c = (cell_mm == 0) ? 1 : int'(cell_mm);
      num = 2 * v + c;
      den = 2 * c;
      q = num / den;
      if (num % den != 0 && num < 0) q--;
      q = q + n / 2;
      if (q < 0) q = 0;
      if (q > n - 1) q = n - 1;
      return q;
   endfunction

   function automatic rsp_type grid_step(req_type r);
      rsp_type o;
      int n, x, y, z, half, col, row, a, changed;
      bit in_box, all_free;
      o = '0;
      o.done_res = 1'b1;
      n = active_side();
      case (r.command)
         CMD_CLEAR: begin
            foreach (grid[i]) grid[i] = CELL_UNKNOWN;
         end
         CMD_POINT: begin
            x = int'(r.point_x); y = int'(r.point_y); z = int'(r.point_z);
            half = int'(box_half);
            in_box = x >= -half && x <= half && y >= -half && y <= half;
            if (in_box && z >= split_h && z <= obst_top) o.point_class = CLASS_OBSTACLE;
            else if (in_box && z >= ground_bot && z < split_h) o.point_class = CLASS_GROUND;
            if (o.point_class != CLASS_NONE) begin
               col = bin_axis(x, n);
               row = bin_axis(y, n);
               a = row * GRID_SIDE + col;
               if (o.point_class == CLASS_OBSTACLE) grid[a] = CELL_OBSTACLE;
               else if (grid[a] != CELL_OBSTACLE)
                  grid[a] = (r.point_intensity < inten_limit) ? CELL_FREE : CELL_BRIGHT;
               o.cell_col = 7'(col);
               o.cell_row = 7'(row);
               o.cell_code = grid[a];
            end
         end
         CMD_FILTER: begin
            changed = 0;
            for (int s = 0; s < n * n; s++) begin
               col = s % n;
               row = s / n;
               if (grid[row*GRID_SIDE+col] != CELL_UNKNOWN) continue;
               if (col == 0 || row == 0 || col + 1 >= n || row + 1 >= n) continue;
               all_free = 1;
               for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++)
                     if ((dr != 0 || dc != 0) &&
                         grid[(row+dr)*GRID_SIDE+col+dc] != CELL_FREE) all_free = 0;
               if (all_free) begin
                  grid[row*GRID_SIDE+col] = CELL_FREE;
                  changed++;
               end
            end
            o.cells_changed = 15'(changed);
         end
         default: begin
            col = (r.read_col > n - 1) ? n - 1 : int'(r.read_col);
            row = (r.read_row > n - 1) ? n - 1 : int'(r.read_row);
            o.cell_col = 7'(col);
            o.cell_row = 7'(row);
            o.cell_code = grid[row*GRID_SIDE+col];
         end
      endcase
      return o;
   endfunction

   // driver: one transfer per item, random gap after each
   int  req_gap = 0;
   bit  req_calm = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps = {expected_rsps, grid_step(req_data)};
            case (req_data.command)
               CMD_CLEAR: n_clears++;
               CMD_POINT: n_points++;
               CMD_FILTER: n_filters++;
               default: n_reads++;
            endcase
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               issued++;
               if ($urandom_range(0, 9) == 0) req_calm = ~req_calm;
               req_gap = req_calm ? 0 : $urandom_range(0, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transfer against the oldest prediction
   int  rsp_stall = 0;
   bit  rsp_calm = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $error("unexpected result transfer %p", rsp_data);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.point_class !== e.point_class) begin
                  errors++;
                  $error("point_class exp %0d got %0d", e.point_class, rsp_data.point_class);
               end
               if (rsp_data.cell_col !== e.cell_col) begin
                  errors++;
                  $error("cell_col exp %0d got %0d", e.cell_col, rsp_data.cell_col);
               end
               if (rsp_data.cell_row !== e.cell_row) begin
                  errors++;
                  $error("cell_row exp %0d got %0d", e.cell_row, rsp_data.cell_row);
               end
               if (rsp_data.cell_code !== e.cell_code) begin
                  errors++;
                  $error("cell_code exp %0d got %0d", e.cell_code, rsp_data.cell_code);
               end
               if (rsp_data.cells_changed !== e.cells_changed) begin
                  errors++;
                  $error("cells_changed exp %0d got %0d", e.cells_changed,
                         rsp_data.cells_changed);
               end
               if (rsp_data.done_res !== e.done_res) begin
                  errors++;
                  $error("done_res exp %0d got %0d", e.done_res, rsp_data.done_res);
               end
            end
            if ($urandom_range(0, 9) == 0) rsp_calm = ~rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 13);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit grid_idle();
      return pending_reqs.size() == 0 && !req_valid && issued == checked &&
             expected_rsps.size() == 0;
   endfunction

   task automatic wait_idle();
      do begin
         while (!grid_idle()) @(posedge clock);
         repeat (40) @(posedge clock);
      end while (!grid_idle());
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      case (idx)
         REG_SPLIT_HEIGHT:  split_h = v;
         REG_OBSTACLE_TOP:  obst_top = v;
         REG_GROUND_BOTTOM: ground_bot = v;
         REG_BOX_HALF:      box_half = v[14:0];
         REG_INTENSITY:     inten_limit = v[7:0];
         REG_CELL_SIZE:     cell_mm = v[12:0];
         default:           side_cfg = v[7:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(int sh, int ot, int gb, int bh, int il, int cs, int cp);
      wait_idle();
      write_reg(REG_SPLIT_HEIGHT, 16'(sh));
      write_reg(REG_OBSTACLE_TOP, 16'(ot));
      write_reg(REG_GROUND_BOTTOM, 16'(gb));
      write_reg(REG_BOX_HALF, 16'(bh));
      write_reg(REG_INTENSITY, 16'(il));
      write_reg(REG_CELL_SIZE, 16'(cs));
      write_reg(REG_CELLS_SIDE, 16'(cp));
      n_phases++;
   endtask

   function automatic req_type noise_req(logic [1:0] cmd);
      req_type r;
      r = ($bits(req_type))'({$urandom, $urandom, $urandom});
      r.command = cmd;
      return r;
   endfunction

   function automatic logic [15:0] clip16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   function automatic int pick(int lo, int hi);
      if (hi <= lo) return lo;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // point aimed at a cell; kind 1 obstacle, 2 ground free, 3 ground bright
   task automatic push_point(int col, int row, int kind);
      req_type r;
      int n, c;
      n = active_side();
      c = (cell_mm == 0) ? 1 : int'(cell_mm);
      r = noise_req(CMD_POINT);
      r.point_x = clip16((col - n / 2) * c + pick(-c / 2, (c - 1) / 2));
      r.point_y = clip16((row - n / 2) * c + pick(-c / 2, (c - 1) / 2));
      if (kind == 1) r.point_z = 16'(pick(split_h, obst_top));
      else r.point_z = 16'(pick(ground_bot, split_h - 1));
      if (kind == 2)
         r.point_intensity = (inten_limit == 0) ? 8'd0 : 8'(pick(0, inten_limit - 1));
      else if (kind == 3) r.point_intensity = 8'(pick(inten_limit, 255));
      queue_req(r);
   endtask

   task automatic random_items(int count, bit heavy_ok);
      int n, k, cc, rr;
      n = active_side();
      while (count > 0) begin
         k = $urandom_range(0, 99);
         if (k < 8 && n >= 3) begin
            // ring of free ground around an empty cell, then filter it if heavy_ok
            cc = pick(1, n - 2);
            rr = pick(1, n - 2);
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0) push_point(cc + dc, rr + dr, 2);
            if (heavy_ok) queue_req(noise_req(CMD_FILTER));
            count -= 9;
         end else if (k < 60) begin
            push_point(pick(0, n - 1), pick(0, n - 1), pick(1, 3));
            count--;
         end else if (k < 72) begin
            queue_req(noise_req(CMD_POINT));
            count--;
         end else if (k < 92) begin
            queue_req(noise_req(CMD_READ));
            count--;
         end else if (k < 97) begin
            if (heavy_ok) queue_req(noise_req(CMD_FILTER));
            count--;
         end else begin
            if (heavy_ok && $urandom_range(0, 2) == 0)
               queue_req(noise_req(CMD_CLEAR));
            count--;
         end
      end
   endtask

   task automatic push_raw(logic [1:0] cmd, int x, int y, int z, int inten,
                           int rc, int rw);
      req_type r;
      r.command = cmd;
      r.point_x = 16'(x);
      r.point_y = 16'(y);
      r.point_z = 16'(z);
      r.point_intensity = 8'(inten);
      r.read_col = 7'(rc);
      r.read_row = 7'(rw);
      queue_req(r);
   endtask

   initial begin
      int sp, n;
      split_h = -1240; obst_top = 0; ground_bot = -2000; box_half = 5000;
      inten_limit = 20; cell_mm = 100; side_cfg = 101;
      foreach (grid[i]) grid[i] = CELL_UNKNOWN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, height and box edges, rounding, saturation
      push_raw(CMD_POINT, 0, 0, -1240, 0, 0, 0);
      push_raw(CMD_POINT, 100, 0, 0, 255, 0, 0);
      push_raw(CMD_POINT, 0, 0, 1, 7, 0, 0);
      push_raw(CMD_POINT, 200, 200, -2000, 19, 0, 0);
      push_raw(CMD_POINT, 300, 200, -1241, 20, 0, 0);
      push_raw(CMD_POINT, 0, 0, -1500, 3, 0, 0);
      push_raw(CMD_POINT, 0, 0, -2001, 3, 0, 0);
      push_raw(CMD_POINT, 5000, -5000, -100, 1, 0, 0);
      push_raw(CMD_POINT, 5001, 0, -100, 1, 0, 0);
      push_raw(CMD_POINT, -5000, 5000, -1900, 0, 0, 0);
      push_raw(CMD_POINT, 50, -50, -100, 0, 0, 0);
      push_raw(CMD_POINT, 32767, -32768, -100, 0, 127, 127);
      push_raw(CMD_READ, 0, 0, 0, 0, 127, 127);
      push_raw(CMD_READ, 0, 0, 0, 0, 0, 0);
      push_raw(CMD_READ, 0, 0, 0, 0, 51, 50);
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) push_point(20 + dc, 20 + dr, 2);
      push_raw(CMD_FILTER, 0, 0, 0, 0, 0, 0);
      push_raw(CMD_READ, 0, 0, 0, 0, 20, 20);
      push_raw(CMD_CLEAR, -1, -1, -1, 255, 127, 127);
      push_raw(CMD_READ, 0, 0, 0, 0, 50, 50);

      // zero cell size and zero side, widest box and height window
      set_regs(-32768, 32767, -32768, 32767, 0, 0, 0);
      push_raw(CMD_POINT, -32768, 32767, -32768, 255, 0, 0);
      push_raw(CMD_POINT, 32767, -32768, 32767, 0, 0, 0);
      random_items(30, 1);

      // largest side, 4096 cell size, zero box half, empty height windows, top intensity limit
      set_regs(32767, -32768, 32767, 0, 255, 4096, 255);
      push_raw(CMD_POINT, 0, 0, 32767, 255, 0, 0);
      push_raw(CMD_POINT, 0, 0, -32768, 254, 0, 0);
      push_raw(CMD_POINT, 1, 0, 0, 0, 0, 0);
      random_items(20, 0);
      set_regs(-1, 32767, -32768, 32767, 255, 4096, 128);
      push_raw(CMD_POINT, 32767, 32767, 5, 0, 0, 0);
      push_raw(CMD_POINT, -32768, -32768, -5, 0, 0, 0);
      push_raw(CMD_POINT, 2047, -2048, -5, 254, 0, 0);
      random_items(20, 0);
      push_raw(CMD_FILTER, 0, 0, 0, 0, 0, 0);

      // random settings with small grids
      repeat (8) begin
         n = pick(3, 16);
         sp = pick(-2000, 1000);
         set_regs(sp, sp + pick(0, 2000), sp - pick(1, 2000),
                  pick(1, 300) * n / 2 + pick(0, 400), pick(1, 255),
                  pick(1, 300), n);
         random_items(40, 1);
      end

      wait_idle();
      $display("tb: %0d points, %0d reads, %0d filters, %0d clears over %0d settings",
               n_points, n_reads, n_filters, n_clears, n_phases + 1);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/locgb_pkg.sv
rtl/lidar_occupancy_grid_builder_top.sv
tb/tb_lidar_occupancy_grid_builder_top.sv
